// File: src/bal_pkg.sv
// Shared types, constants and control bundle for the bounded array list.
package bal_pkg;

  localparam int DataW     = 32;
  localparam int CntW      = 5;
  localparam int DepthDef  = 16;
  localparam logic [CntW-1:0] CapReset = 5'd16;

  // Operation codes carried on the mode port
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT_AT  = 3'd4,
    MODE_PEEK_LAST  = 3'd5,
    MODE_SEARCH     = 3'd6
  } mode_t;

  // Broadcast control from the top level to every cell of the chain
  typedef struct packed {
    logic                    up;     // cells above 'at' take the lower neighbor
    logic                    down;   // every cell takes the upper neighbor
    logic                    wr;     // cell at 'at' takes 'value'
    logic [CntW-1:0]         at;
    logic [CntW-1:0]         count;  // entries held before this beat
    logic signed [DataW-1:0] value;  // value to write or key to search for
  } bal_ctl_t;

endpackage

// File: src/bal_cell.sv
// One storage cell of the list chain: hold, shift or load, and compare.
module bal_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  bal_pkg::bal_ctl_t             ctl,
  input  logic signed [bal_pkg::DataW-1:0] lower,
  input  logic signed [bal_pkg::DataW-1:0] upper,
  output logic signed [bal_pkg::DataW-1:0] value,
  output logic                          hit,
  output logic signed [bal_pkg::DataW-1:0] last_data
);
  import bal_pkg::*;

  logic signed [DataW-1:0] value_next;
  logic                    in_use;
  logic                    is_last;

  // Pick the next content of this cell
  always_comb begin
    priority if (ctl.wr && (IDX == int'(ctl.at))) begin
      value_next = ctl.value;
    end else if (ctl.up && (IDX > int'(ctl.at))) begin
      value_next = lower;
    end else if (ctl.down) begin
      value_next = upper;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Match and last-entry taps for the search and peek reductions
  assign in_use    = IDX < int'(ctl.count);
  assign is_last   = (IDX + 1) == int'(ctl.count);
  assign hit       = in_use && (value == ctl.value);
  assign last_data = is_last ? value : '0;

endmodule

// File: src/bounded_array_list.sv
// Top level of the bounded array list: control, count and the chain of cells.
//
//  channel   signals                               beat taken when
//  --------  ------------------------------------  ----------------------
//  command   start, mode, item_value, position     start high, busy low
//  result    done, ok, data, count, is_empty,      done high (one cycle)
//            is_full
//  config    cfg_we, cfg_wdata (capacity)          cfg_we high
//
// Every operation, shifts and search included, needs no sequencing: all
// cells of the chain shift or compare together, and the result appears on
// the cycle after the command beat. busy stays low, so a command may come
// every cycle. Reset empties the list and sets capacity to 16; cell contents
// are not cleared. The receiver cannot stall, so results never wait.
module bounded_array_list #(
  parameter int DEPTH = bal_pkg::DepthDef
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       mode,
  input  logic signed [bal_pkg::DataW-1:0] item_value,
  input  logic [bal_pkg::CntW-1:0]         position,
  output logic                             done,
  output logic                             ok,
  output logic signed [bal_pkg::DataW-1:0] data,
  output logic [bal_pkg::CntW-1:0]         count,
  output logic                             is_empty,
  output logic                             is_full,
  input  logic                             cfg_we,
  input  logic [bal_pkg::CntW-1:0]         cfg_wdata
);
  import bal_pkg::*;

  // Largest count the chain can hold, clipped to what the count field carries
  localparam logic [CntW-1:0] DepthCap = (DEPTH > 31) ? 5'd31 : 5'(DEPTH);

  logic [CntW-1:0]         capacity;
  logic [CntW-1:0]         item_count;
  logic [CntW-1:0]         item_count_next;
  logic [CntW-1:0]         eff_cap;
  logic                    accept;
  logic                    room;
  logic                    nonempty;
  logic                    ok_next;
  logic signed [DataW-1:0] data_next;
  logic                    hit_any;
  logic signed [DataW-1:0] last_value;
  bal_ctl_t                ctl;

  logic signed [DataW-1:0] cell_value [DEPTH];
  logic                    cell_hit   [DEPTH];
  logic signed [DataW-1:0] cell_last  [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign eff_cap  = (capacity > DepthCap) ? DepthCap : capacity;
  assign room     = item_count < eff_cap;
  assign nonempty = item_count != '0;

  // Reduce the per-cell match and last-entry taps
  always_comb begin
    hit_any    = 1'b0;
    last_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_any    = hit_any | cell_hit[i];
      last_value = last_value | cell_last[i];
    end
  end

  // Decode the command into chain control, result and next count
  always_comb begin
    ctl             = '0;
    ctl.count       = item_count;
    ctl.value       = item_value;
    ok_next         = 1'b0;
    data_next       = '0;
    item_count_next = item_count;
    unique case (mode_t'(mode))
      MODE_PUSH_FRONT: begin
        if (room) begin
          ctl.up          = 1'b1;
          ctl.wr          = 1'b1;
          ctl.at          = '0;
          ok_next         = 1'b1;
          item_count_next = item_count + 5'd1;
        end
      end
      MODE_PUSH_BACK: begin
        if (room) begin
          ctl.wr          = 1'b1;
          ctl.at          = item_count;
          ok_next         = 1'b1;
          item_count_next = item_count + 5'd1;
        end
      end
      MODE_POP_BACK: begin
        if (nonempty) begin
          ok_next         = 1'b1;
          data_next       = last_value;
          item_count_next = item_count - 5'd1;
        end
      end
      MODE_POP_FRONT: begin
        if (nonempty) begin
          ctl.down        = 1'b1;
          ok_next         = 1'b1;
          item_count_next = item_count - 5'd1;
        end
      end
      MODE_INSERT_AT: begin
        if (room && (position <= item_count)) begin
          ctl.up          = 1'b1;
          ctl.wr          = 1'b1;
          ctl.at          = position;
          ok_next         = 1'b1;
          item_count_next = item_count + 5'd1;
        end
      end
      MODE_PEEK_LAST: begin
        if (nonempty) begin
          ok_next   = 1'b1;
          data_next = last_value;
        end
      end
      MODE_SEARCH: begin
        ok_next = hit_any;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    // Drop all cell writes unless a command beat is taken
    if (!accept) begin
      ctl.up   = 1'b0;
      ctl.down = 1'b0;
      ctl.wr   = 1'b0;
    end
  end

  // Hold count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
      capacity   <= CapReset;
    end else begin
      if (accept) begin
        item_count <= item_count_next;
      end
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  // Strobe the result in the cycle after the command beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok       <= ok_next;
      data     <= data_next;
      count    <= item_count_next;
      is_empty <= item_count_next == '0;
      is_full  <= item_count_next >= eff_cap;
    end
  end

  // Chain of cells, each fed by its lower and upper neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] lower;
    logic signed [DataW-1:0] upper;
    if (g == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_value[g+1];
    end
    bal_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .lower    (lower),
      .upper    (upper),
      .value    (cell_value[g]),
      .hit      (cell_hit[g]),
      .last_data(cell_last[g])
    );
  end

endmodule
